@@ rtl/core/mm61sq_pkg.sv @@
// Package for the modular multiplier modulo (2^61-1)^2.
// Holds widths, the modulus, the beat type of the multiply chain and a width helper.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package mm61sq_pkg;

  // Operand and product geometry.
  localparam int unsigned OPND_W     = 122;
  localparam int unsigned PROD_W     = 2 * OPND_W;
  localparam int unsigned LIMB_W     = 32;
  localparam int unsigned N_LIMB     = 4;
  localparam int unsigned LIMB_EXT_W = LIMB_W * N_LIMB;
  localparam int unsigned PP_W       = 2 * LIMB_W;

  // Folding: 2^122 is congruent to 2^62 - 1 modulo M.
  localparam int unsigned RED_W      = OPND_W;
  localparam int unsigned FOLD_SHIFT = 62;

  // Stream widths, padded to whole bytes.
  localparam int unsigned IN_TDATA_W  = 248;
  localparam int unsigned OUT_TDATA_W = 128;

  // M = 2^122 - 2^62 + 1: ones in bits 121..62, plus one.
  localparam logic [OPND_W-1:0] MODULUS = {{(OPND_W-FOLD_SHIFT){1'b1}},
                                           (FOLD_SHIFT)'(1)};

  // Beat that moves along the multiply chain.
  typedef struct packed {
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
    logic [PROD_W-1:0] acc;
  } mul_beat_t;

  // Width needed after one fold of a value that is in_w bits wide.
  function automatic int unsigned fold_out_w(input int unsigned in_w);
    int unsigned hi_w;
    int unsigned top_w;
    hi_w  = in_w - RED_W;
    top_w = hi_w + FOLD_SHIFT;
    if (top_w < RED_W) begin
      top_w = RED_W;
    end
    return top_w + 1;
  endfunction

endpackage

@@ rtl/core/mm61sq_mul_cell.sv @@
// One multiply cell: limb K of operand A times all limbs of B, added into the accumulator.
// Two register stages (partial products, then accumulate). Depends on mm61sq_pkg.
module mm61sq_mul_cell #(
  parameter int unsigned K = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  mm61sq_pkg::mul_beat_t in_beat_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output mm61sq_pkg::mul_beat_t out_beat_o
);

  localparam int unsigned LW = mm61sq_pkg::LIMB_W;
  localparam int unsigned PW = mm61sq_pkg::PP_W;
  localparam int unsigned AW = mm61sq_pkg::PROD_W;
  localparam int unsigned NL = mm61sq_pkg::N_LIMB;

  logic [mm61sq_pkg::LIMB_EXT_W-1:0] a_ext;
  logic [mm61sq_pkg::LIMB_EXT_W-1:0] b_ext;
  logic [LW-1:0]                     a_limb;
  logic [PW-1:0]                     pp_d [NL];
  logic [PW-1:0]                     pp_q [NL];
  mm61sq_pkg::mul_beat_t             s1_beat_q;
  logic                              s1_valid_q;
  logic                              s1_ready;
  logic                              s2_ready;
  logic [2*PW-1:0]                   even_pp;
  logic [2*PW-1:0]                   odd_pp;
  logic [AW-1:0]                     acc_d;
  mm61sq_pkg::mul_beat_t             s2_beat_q;
  logic                              s2_valid_q;

  // Operands widened to whole limbs.
  assign a_ext  = mm61sq_pkg::LIMB_EXT_W'(in_beat_i.a);
  assign b_ext  = mm61sq_pkg::LIMB_EXT_W'(in_beat_i.b);
  assign a_limb = a_ext[LW*K +: LW];

  // Row of 32 by 32 partial products.
  for (genvar j = 0; j < NL; j++) begin : g_pp
    assign pp_d[j] = PW'(a_limb) * PW'(b_ext[LW*j +: LW]);
  end

  // Stage ready chain: a stage moves when it is empty or its successor takes the beat.
  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  // Stage one: partial product registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_beat_q <= in_beat_i;
      for (int j = 0; j < NL; j++) begin
        pp_q[j] <= pp_d[j];
      end
    end
  end

  // Even products do not overlap, nor do odd ones, so the row is one add of two words.
  assign even_pp = {pp_q[2], pp_q[0]};
  assign odd_pp  = {pp_q[3], pp_q[1]};
  assign acc_d   = s1_beat_q.acc
                 + (AW'(even_pp) << (LW*K))
                 + (AW'(odd_pp)  << (LW*K + LW));

  // Stage two: accumulator register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      s2_beat_q.a   <= s1_beat_q.a;
      s2_beat_q.b   <= s1_beat_q.b;
      s2_beat_q.acc <= acc_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_beat_o  = s2_beat_q;

endmodule

@@ rtl/core/mm61sq_fold_cell.sv @@
// One fold cell: x' = (x >> 122) * (2^62 - 1) + (x mod 2^122), registered.
// The output width shrinks with each fold until it settles at 123 bits. Depends on mm61sq_pkg.
module mm61sq_fold_cell #(
  parameter int unsigned IN_W = 244
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [IN_W-1:0]                        x_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [mm61sq_pkg::fold_out_w(IN_W)-1:0] x_o
);

  localparam int unsigned RW    = mm61sq_pkg::RED_W;
  localparam int unsigned HI_W  = IN_W - RW;
  localparam int unsigned OUT_W = mm61sq_pkg::fold_out_w(IN_W);

  logic [HI_W-1:0]  hi;
  logic [RW-1:0]    lo;
  logic [OUT_W-1:0] x_d;
  logic [OUT_W-1:0] x_q;
  logic             valid_q;

  // Split and fold; the true result fits in OUT_W, so modular arithmetic is exact.
  assign hi  = x_i[IN_W-1:RW];
  assign lo  = x_i[RW-1:0];
  assign x_d = OUT_W'({hi, {mm61sq_pkg::FOLD_SHIFT{1'b0}}}) + OUT_W'(lo) - OUT_W'(hi);

  assign in_ready_o = !valid_q || out_ready_i;

  // Valid flag of the cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Folded value register.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      x_q <= x_d;
    end
  end

  assign out_valid_o = valid_q;
  assign x_o         = x_q;

endmodule

@@ rtl/core/mm61sq_final_cell.sv @@
// Final cell: one conditional subtraction of the modulus, into the output register.
// Its input comes from the last fold. Depends on mm61sq_pkg.
module mm61sq_final_cell #(
  parameter int unsigned IN_W = 123
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [IN_W-1:0]               x_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mm61sq_pkg::OPND_W-1:0] result_o
);

  localparam int unsigned RW = mm61sq_pkg::OPND_W;

  // After four folds the value stays below 2^122 + 2^62.
  localparam logic [IN_W-1:0] FOLD_BOUND = (IN_W'(1) << mm61sq_pkg::RED_W)
                                         + (IN_W'(1) << mm61sq_pkg::FOLD_SHIFT);

  logic [IN_W:0]   diff;
  logic            borrow;
  logic [RW-1:0]   result_d;
  logic [RW-1:0]   result_q;
  logic            valid_q;

  // Subtract M; a borrow means the value was already reduced.
  assign diff     = (IN_W+1)'(x_i) - (IN_W+1)'(mm61sq_pkg::MODULUS);
  assign borrow   = diff[IN_W];
  assign result_d = borrow ? x_i[RW-1:0] : diff[RW-1:0];

  assign in_ready_o = !valid_q || out_ready_i;

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Output data register.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

`ifndef SYNTHESIS
  // The folds must leave a value that one subtraction fully reduces.
  a_fold_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |-> (x_i < FOLD_BOUND))
    else $error("folded value exceeds the single subtraction range");
`endif

endmodule

@@ rtl/core/mod_mul_mersenne61_squared.sv @@
// Modular multiplier modulo M = (2^61-1)^2 = 2^122 - 2^62 + 1. Each input beat carries two
// 122-bit operands and yields one beat with A*B mod M, fully reduced below M for any operand
// pattern. It takes one beat per clock and returns one per clock with a ready downstream. The
// path is four multiply cells of two stages each (sixteen 32x32 multipliers in all, one row
// per cell), four fold cells and the final subtract stage, which is the output register. Each
// cell moves on when it is empty or its successor takes its beat, so bubbles are squeezed out
// and new beats enter while a result waits at the output. No state is kept between beats.
// Input tdata: a_low, a_high, b_low, b_high from bit 0 up; output tdata: product_low,
// product_high from bit 0 up.
module mod_mul_mersenne61_squared (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // Fields from bit 0: a_low[63:0], a_high[121:64], b_low[185:122], b_high[243:186], zero pad.
  input  logic [mm61sq_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // Fields from bit 0: product_low[63:0], product_high[121:64], zero pad.
  output logic [mm61sq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o
);

  localparam int unsigned OW = mm61sq_pkg::OPND_W;
  localparam int unsigned NL = mm61sq_pkg::N_LIMB;
  localparam int unsigned W0 = mm61sq_pkg::PROD_W;
  localparam int unsigned W1 = mm61sq_pkg::fold_out_w(W0);
  localparam int unsigned W2 = mm61sq_pkg::fold_out_w(W1);
  localparam int unsigned W3 = mm61sq_pkg::fold_out_w(W2);
  localparam int unsigned W4 = mm61sq_pkg::fold_out_w(W3);

  logic                  mul_valid [NL+1];
  logic                  mul_ready [NL+1];
  mm61sq_pkg::mul_beat_t mul_beat  [NL+1];

  logic          f1_valid, f1_ready, f2_valid, f2_ready;
  logic          f3_valid, f3_ready, f4_valid, f4_ready;
  logic [W1-1:0] f1_x;
  logic [W2-1:0] f2_x;
  logic [W3-1:0] f3_x;
  logic [W4-1:0] f4_x;
  logic [OW-1:0] result;

  // Unpack operands; the accumulator starts at zero.
  assign mul_valid[0]    = s_axis_tvalid_i;
  assign s_axis_tready_o = mul_ready[0];
  assign mul_beat[0].a   = s_axis_tdata_i[OW-1:0];
  assign mul_beat[0].b   = s_axis_tdata_i[2*OW-1:OW];
  assign mul_beat[0].acc = '0;

  // Multiply chain, one limb of A per cell.
  for (genvar k = 0; k < NL; k++) begin : g_mul
    mm61sq_mul_cell #(
      .K(k)
    ) u_mul_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (mul_valid[k]),
      .in_ready_o (mul_ready[k]),
      .in_beat_i  (mul_beat[k]),
      .out_valid_o(mul_valid[k+1]),
      .out_ready_i(mul_ready[k+1]),
      .out_beat_o (mul_beat[k+1])
    );
  end

  // Four folds of the full product.
  mm61sq_fold_cell #(.IN_W(W0)) u_fold1 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (mul_valid[NL]),
    .in_ready_o (mul_ready[NL]),
    .x_i        (mul_beat[NL].acc),
    .out_valid_o(f1_valid),
    .out_ready_i(f1_ready),
    .x_o        (f1_x)
  );

  mm61sq_fold_cell #(.IN_W(W1)) u_fold2 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (f1_valid),
    .in_ready_o (f1_ready),
    .x_i        (f1_x),
    .out_valid_o(f2_valid),
    .out_ready_i(f2_ready),
    .x_o        (f2_x)
  );

  mm61sq_fold_cell #(.IN_W(W2)) u_fold3 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (f2_valid),
    .in_ready_o (f2_ready),
    .x_i        (f2_x),
    .out_valid_o(f3_valid),
    .out_ready_i(f3_ready),
    .x_o        (f3_x)
  );

  mm61sq_fold_cell #(.IN_W(W3)) u_fold4 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (f3_valid),
    .in_ready_o (f3_ready),
    .x_i        (f3_x),
    .out_valid_o(f4_valid),
    .out_ready_i(f4_ready),
    .x_o        (f4_x)
  );

  // Conditional subtraction and output register.
  mm61sq_final_cell #(.IN_W(W4)) u_final (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (f4_valid),
    .in_ready_o (f4_ready),
    .x_i        (f4_x),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .result_o   (result)
  );

  assign m_axis_tdata_o = mm61sq_pkg::OUT_TDATA_W'(result);

`ifndef SYNTHESIS
  // Every delivered product is fully reduced.
  a_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[OW-1:0] < mm61sq_pkg::MODULUS))
    else $error("result not below the modulus");

  // With the output register empty, the ready chain must be open end to end.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled while the output register is empty");
`endif

endmodule
